// File: rtl/ultrasonic_ping_ranger_defines.svh
// Assertion macros for the ping ranger.
`ifndef ULTRASONIC_PING_RANGER_DEFINES_SVH
`define ULTRASONIC_PING_RANGER_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define UPR_ASSERT(lbl, prop) lbl: assert property (@(posedge aclk) disable iff (!aresetn) \
    prop) else $error("ultrasonic_ping_ranger: check failed");
`define UPR_ASSERT_ALWAYS(lbl, prop) lbl: assert property (@(posedge aclk) prop) \
    else $error("ultrasonic_ping_ranger: check failed");
`else
`define UPR_ASSERT(lbl, prop)
`define UPR_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

// File: rtl/upr_pkg.sv
package upr_pkg;

    localparam int PCNT_W = 20;
    localparam int ECNT_W = 16;
    localparam int DIST_W = 10;
    localparam int TPC_W  = 8;
    localparam int CFG_W  = 20;
    localparam int ADDR_W = 3;
    localparam int OUT_CH = 4;

    typedef enum logic [1:0] {
        PH_REST,
        PH_TRIG,
        PH_ARMED,
        PH_CAPT
    } phase_t;

    typedef enum logic [2:0] {
        SQ_IDLE,
        SQ_READ,
        SQ_CALC,
        SQ_DIV,
        SQ_FIN,
        SQ_OUT
    } seq_t;

    typedef enum logic [ADDR_W-1:0] {
        REG_TRIGGER_TICKS,
        REG_ECHO_TIMEOUT_TICKS,
        REG_REST_TICKS,
        REG_TICKS_PER_CM,
        REG_MIN_ECHO_TICKS,
        REG_MAX_DISTANCE_CM,
        REG_NO_ECHO_CODE,
        REG_CHANNEL_ENABLE
    } reg_idx_t;

    typedef struct packed {
        phase_t              phase;
        logic [PCNT_W-1:0]   pcnt;
        logic [ECNT_W-1:0]   ecnt;
        logic                prev;
        logic [DIST_W-1:0]   dist_cm;
    } chan_state_t;

endpackage

// File: rtl/ultrasonic_ping_ranger.sv
// Channel    | Dir | Beat
// s_ (tdata) | in  | one 1 us tick: echo_levels
// m_ (tdata) | out | one result per tick: trigger lines, four distances, update mask
// cfg_       | in  | register write, index per register list
//
// A tick steps each channel through the read, calc and finish states, with divide steps added for each channel whose
// echo pulse ends on that tick (bit-serial divider by ticks_per_cm), then one output state.
// Per-channel state sits in one single-port memory, read-modify-write per channel.
// Reset is synchronous, active low; valid bits make unwritten entries read as zero.
// A new tick is taken while the previous result waits in the output register.
module ultrasonic_ping_ranger #(
    parameter int CHANNELS = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [3:0] echo_levels
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [3:0] trigger_lines, [13:4] distance_front,
                                   // [23:14] distance_back, [33:24] distance_left,
                                   // [43:34] distance_right, [47:44] updated_mask
    input  logic        cfg_we,
    input  logic [upr_pkg::ADDR_W-1:0] cfg_addr,
    input  logic [upr_pkg::CFG_W-1:0]  cfg_wdata
);

    localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int PW = upr_pkg::PCNT_W;
    localparam int EW = upr_pkg::ECNT_W;
    localparam int DW = upr_pkg::DIST_W;
    localparam int TW = upr_pkg::TPC_W;

    // configuration
    logic [7:0]    trig_ticks_reg;
    logic [15:0]   timeout_reg;
    logic [19:0]   rest_ticks_reg;
    logic [TW-1:0] tpc_reg;
    logic [15:0]   min_echo_reg;
    logic [DW-1:0] max_dist_reg;
    logic [DW-1:0] no_echo_reg;
    logic [3:0]    chan_en_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            trig_ticks_reg <= 8'd10;
            timeout_reg    <= 16'd30000;
            rest_ticks_reg <= 20'd100000;
            tpc_reg        <= 8'd58;
            min_echo_reg   <= 16'd116;
            max_dist_reg   <= 10'd400;
            no_echo_reg    <= 10'd999;
            chan_en_reg    <= 4'hF;
        end else if (cfg_we) begin
            case (upr_pkg::reg_idx_t'(cfg_addr))
                upr_pkg::REG_TRIGGER_TICKS:      trig_ticks_reg <= cfg_wdata[7:0];
                upr_pkg::REG_ECHO_TIMEOUT_TICKS: timeout_reg    <= cfg_wdata[15:0];
                upr_pkg::REG_REST_TICKS:         rest_ticks_reg <= cfg_wdata[19:0];
                upr_pkg::REG_TICKS_PER_CM:       tpc_reg        <= cfg_wdata[7:0];
                upr_pkg::REG_MIN_ECHO_TICKS:     min_echo_reg   <= cfg_wdata[15:0];
                upr_pkg::REG_MAX_DISTANCE_CM:    max_dist_reg   <= cfg_wdata[9:0];
                upr_pkg::REG_NO_ECHO_CODE:       no_echo_reg    <= cfg_wdata[9:0];
                upr_pkg::REG_CHANNEL_ENABLE:     chan_en_reg    <= cfg_wdata[3:0];
                default: ;
            endcase
        end
    end

    // sequencer
    upr_pkg::seq_t state_reg, state_next;
    logic [CH_W-1:0] ch_reg;
    logic last_ch;
    logic need_div;
    logic mem_we;
    logic load_out;
    logic [3:0] bit_cnt_reg;

    assign last_ch = (ch_reg == CH_W'(CHANNELS - 1));

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            upr_pkg::SQ_IDLE: if (s_tvalid) state_next = upr_pkg::SQ_READ;
            upr_pkg::SQ_READ: state_next = upr_pkg::SQ_CALC;
            upr_pkg::SQ_CALC: state_next = need_div ? upr_pkg::SQ_DIV : upr_pkg::SQ_FIN;
            upr_pkg::SQ_DIV:  if (bit_cnt_reg == 4'hF) state_next = upr_pkg::SQ_FIN;
            upr_pkg::SQ_FIN:  state_next = last_ch ? upr_pkg::SQ_OUT : upr_pkg::SQ_READ;
            upr_pkg::SQ_OUT:  if (!m_tvalid || m_tready) state_next = upr_pkg::SQ_IDLE;
            default:          state_next = upr_pkg::SQ_IDLE;
        endcase
    end

    always_comb begin
        s_tready = (state_reg == upr_pkg::SQ_IDLE);
        mem_we   = (state_reg == upr_pkg::SQ_FIN);
        load_out = (state_reg == upr_pkg::SQ_OUT) && (!m_tvalid || m_tready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= upr_pkg::SQ_IDLE;
            ch_reg    <= '0;
        end else begin
            state_reg <= state_next;
            if (s_tvalid && s_tready) begin
                ch_reg <= '0;
            end else if (mem_we && !last_ch) begin
                ch_reg <= ch_reg + 1'b1;
            end
        end
    end

    // tick input
    logic [3:0] lvl_reg;
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            lvl_reg <= s_tdata[3:0];
        end
    end

    logic [CHANNELS-1:0] lvl_vec;
    logic [CHANNELS-1:0] en_vec;
    for (genvar i = 0; i < CHANNELS; i++) begin : g_ch
        if (i < upr_pkg::OUT_CH) begin : g_pin
            assign lvl_vec[i] = lvl_reg[i];
            assign en_vec[i]  = chan_en_reg[i];
        end else begin : g_nopin
            assign lvl_vec[i] = 1'b0;
            assign en_vec[i]  = 1'b0;
        end
    end

    // channel state memory
    upr_pkg::chan_state_t mem [CHANNELS];
    upr_pkg::chan_state_t rd_ent_reg;
    upr_pkg::chan_state_t wr_ent;
    logic [CHANNELS-1:0] valid_reg;
    logic rd_valid_reg;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[ch_reg] <= wr_ent;
        end
        rd_ent_reg <= mem[ch_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            rd_valid_reg <= valid_reg[ch_reg];
            if (mem_we) begin
                valid_reg[ch_reg] <= 1'b1;
            end
        end
    end

    // per-channel update
    upr_pkg::chan_state_t cur, nxt;
    logic          lvl, en, edge_seen, done;
    logic [PW-1:0] pinc;
    logic [EW-1:0] einc;

    always_comb begin
        cur       = rd_valid_reg ? rd_ent_reg : '0;
        lvl       = lvl_vec[ch_reg];
        en        = en_vec[ch_reg];
        edge_seen = (lvl != cur.prev);
        pinc      = (cur.pcnt == '1) ? cur.pcnt : cur.pcnt + 1'b1;
        einc      = (cur.ecnt == '1) ? cur.ecnt : cur.ecnt + 1'b1;
        nxt       = cur;
        nxt.prev  = lvl;
        done      = 1'b0;
        need_div  = 1'b0;
        if (!en) begin
            nxt.phase = upr_pkg::PH_REST;
            nxt.pcnt  = '0;
        end else begin
            case (cur.phase)
                upr_pkg::PH_REST: begin
                    if (cur.pcnt >= rest_ticks_reg) begin
                        nxt.phase = upr_pkg::PH_TRIG;
                        nxt.pcnt  = '0;
                    end else begin
                        nxt.pcnt = pinc;
                    end
                end
                upr_pkg::PH_TRIG: begin
                    if (pinc >= PW'(trig_ticks_reg)) begin
                        nxt.phase = upr_pkg::PH_ARMED;
                        nxt.pcnt  = '0;
                    end else begin
                        nxt.pcnt = pinc;
                    end
                end
                default: begin
                    if (cur.phase == upr_pkg::PH_ARMED) begin
                        if (edge_seen) begin
                            nxt.phase = upr_pkg::PH_CAPT;
                            nxt.ecnt  = '0;
                        end
                    end else begin
                        nxt.ecnt = einc;
                        done     = edge_seen;
                    end
                    if (done) begin
                        nxt.phase = upr_pkg::PH_REST;
                        nxt.pcnt  = '0;
                        need_div  = 1'b1;
                    end else if (pinc >= PW'(timeout_reg)) begin
                        nxt.dist_cm = no_echo_reg;
                        nxt.phase   = upr_pkg::PH_REST;
                        nxt.pcnt    = '0;
                    end else begin
                        nxt.pcnt = pinc;
                    end
                end
            endcase
        end
    end

    // bit-serial divider, width / ticks_per_cm
    upr_pkg::chan_state_t ent_reg;
    logic [DW-1:0] old_dist_reg;
    logic          div_pend_reg;
    logic [EW-1:0] quo_reg;
    logic [TW-1:0] rem_reg;
    logic [TW:0]   trial;
    logic          trial_ge;

    assign trial    = {rem_reg, quo_reg[EW-1]};
    assign trial_ge = (trial >= {1'b0, tpc_reg});

    always_ff @(posedge aclk) begin
        if (state_reg == upr_pkg::SQ_CALC) begin
            ent_reg      <= nxt;
            old_dist_reg <= cur.dist_cm;
            div_pend_reg <= need_div;
            quo_reg      <= nxt.ecnt;
            rem_reg      <= '0;
            bit_cnt_reg  <= '0;
        end else if (state_reg == upr_pkg::SQ_DIV) begin
            quo_reg     <= {quo_reg[EW-2:0], trial_ge};
            rem_reg     <= trial_ge ? TW'(trial - {1'b0, tpc_reg}) : trial[TW-1:0];
            bit_cnt_reg <= bit_cnt_reg + 1'b1;
        end
    end

    logic [DW-1:0] meas_dist, fin_dist;
    always_comb begin
        if (tpc_reg == '0 || ent_reg.ecnt < min_echo_reg || quo_reg > EW'(max_dist_reg)) begin
            meas_dist = no_echo_reg;
        end else begin
            meas_dist = quo_reg[DW-1:0];
        end
        fin_dist       = div_pend_reg ? meas_dist : ent_reg.dist_cm;
        wr_ent         = ent_reg;
        wr_ent.dist_cm = fin_dist;
    end

    // per-tick result collection
    logic [CHANNELS-1:0] trig_acc_reg, upd_acc_reg;
    logic [DW-1:0] dist_out_reg [upr_pkg::OUT_CH];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            trig_acc_reg <= '0;
            upd_acc_reg  <= '0;
            for (int i = 0; i < upr_pkg::OUT_CH; i++) begin
                dist_out_reg[i] <= '0;
            end
        end else if (s_tvalid && s_tready) begin
            trig_acc_reg <= '0;
            upd_acc_reg  <= '0;
        end else if (mem_we) begin
            trig_acc_reg[ch_reg] <= (ent_reg.phase == upr_pkg::PH_TRIG);
            upd_acc_reg[ch_reg]  <= (fin_dist != old_dist_reg);
            for (int i = 0; i < upr_pkg::OUT_CH; i++) begin
                if (32'(ch_reg) == i) begin
                    dist_out_reg[i] <= fin_dist;
                end
            end
        end
    end

    logic [3:0] trig4, upd4;
    for (genvar i = 0; i < upr_pkg::OUT_CH; i++) begin : g_mask
        if (i < CHANNELS) begin : g_on
            assign trig4[i] = trig_acc_reg[i];
            assign upd4[i]  = upd_acc_reg[i];
        end else begin : g_off
            assign trig4[i] = 1'b0;
            assign upd4[i]  = 1'b0;
        end
    end

    // output register
    logic        m_tvalid_reg;
    logic [47:0] m_tdata_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (load_out) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            m_tdata_reg <= {upd4, dist_out_reg[3], dist_out_reg[2], dist_out_reg[1],
                            dist_out_reg[0], trig4};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    `include "ultrasonic_ping_ranger_defines.svh"

    `UPR_ASSERT(a_tick_starts_at_ch0, (s_tvalid && s_tready) |=> (state_reg == upr_pkg::SQ_READ && ch_reg == '0))
    `UPR_ASSERT(a_div_rem_bound, (state_reg == upr_pkg::SQ_DIV && tpc_reg != '0) |-> (rem_reg < tpc_reg))
    `UPR_ASSERT(a_trig_only_enabled, m_tvalid |-> ((m_tdata[3:0] & ~chan_en_reg) == 4'b0))

endmodule

// File: verif/tb_ultrasonic_ping_ranger.sv
`timescale 1ns / 1ps

module tb_ultrasonic_ping_ranger;

    typedef struct packed {
        logic [3:0] upd_mask;
        logic [9:0] dist_right;
        logic [9:0] dist_left;
        logic [9:0] dist_back;
        logic [9:0] dist_front;
        logic [3:0] trig_lines;
    } tick_out_t;

    typedef enum logic [1:0] {
        ROW_WRITE,
        ROW_TICK,
        ROW_KNOWN
    } row_kind_t;

    typedef struct {
        row_kind_t         kind;
        upr_pkg::reg_idx_t idx;
        logic [19:0]       val;
        logic [3:0]        lv;
        tick_out_t         want;
    } dir_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic        cfg_we = 1'b0;
    logic [upr_pkg::ADDR_W-1:0] cfg_addr = '0;
    logic [upr_pkg::CFG_W-1:0]  cfg_wdata = '0;

    ultrasonic_ping_ranger dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always #1 aclk = ~aclk;

    // register mirrors
    logic [7:0]  trig_len;
    logic [15:0] timeout_len;
    logic [19:0] rest_len;
    logic [7:0]  cm_div;
    logic [15:0] min_echo;
    logic [9:0]  max_cm;
    logic [9:0]  no_echo;
    logic [3:0]  en_mask;

    // per-channel mirrors
    upr_pkg::phase_t ch_phase [4];
    logic [19:0]     ch_pcnt  [4];
    logic [15:0]     ch_ecnt  [4];
    logic            ch_prev  [4];
    logic [9:0]      ch_dist  [4];

    tick_out_t expected_q[$];
    dir_row_t  dir_rows[$];

    int  mismatches = 0;
    int  ticks_sent = 0;
    int  results_seen = 0;
    int  updates_seen = 0;
    int  cfg_settings = 0;
    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    bit  cfg_open = 1'b0;
    logic hold_off = 1'b0;

    function automatic void ranger_reset();
        trig_len    = 8'd10;
        timeout_len = 16'd30000;
        rest_len    = 20'd100000;
        cm_div      = 8'd58;
        min_echo    = 16'd116;
        max_cm      = 10'd400;
        no_echo     = 10'd999;
        en_mask     = 4'hF;
        for (int c = 0; c < 4; c++) begin
            ch_phase[c] = upr_pkg::PH_REST;
            ch_pcnt[c]  = '0;
            ch_ecnt[c]  = '0;
            ch_prev[c]  = 1'b0;
            ch_dist[c]  = '0;
        end
    endfunction

    function automatic void shadow_write(upr_pkg::reg_idx_t idx, logic [19:0] v);
        case (idx)
            upr_pkg::REG_TRIGGER_TICKS:      trig_len    = v[7:0];
            upr_pkg::REG_ECHO_TIMEOUT_TICKS: timeout_len = v[15:0];
            upr_pkg::REG_REST_TICKS:         rest_len    = v[19:0];
            upr_pkg::REG_TICKS_PER_CM:       cm_div      = v[7:0];
            upr_pkg::REG_MIN_ECHO_TICKS:     min_echo    = v[15:0];
            upr_pkg::REG_MAX_DISTANCE_CM:    max_cm      = v[9:0];
            upr_pkg::REG_NO_ECHO_CODE:       no_echo     = v[9:0];
            upr_pkg::REG_CHANNEL_ENABLE:     en_mask     = v[3:0];
            default: ;
        endcase
    endfunction

    function automatic logic [19:0] bump20(logic [19:0] x);
        return (x == 20'hFFFFF) ? x : x + 20'd1;
    endfunction

    function automatic logic [9:0] echo_to_cm(logic [15:0] w);
        logic [15:0] q;
        if (cm_div == 8'd0) return no_echo;
        q = w / cm_div;
        if (w < min_echo || q > max_cm) return no_echo;
        return q[9:0];
    endfunction

    function automatic tick_out_t ranger_tick(logic [3:0] lv);
        tick_out_t  o;
        logic [9:0] old_d;
        logic       lvl_change;
        logic       finished;
        o = '0;
        for (int c = 0; c < 4; c++) begin
            lvl_change = (lv[c] != ch_prev[c]);
            old_d = ch_dist[c];
            ch_prev[c] = lv[c];
            if (!en_mask[c]) begin
                ch_phase[c] = upr_pkg::PH_REST;
                ch_pcnt[c]  = '0;
            end else begin
                case (ch_phase[c])
                    upr_pkg::PH_REST: begin
                        if (ch_pcnt[c] >= rest_len) begin
                            ch_phase[c] = upr_pkg::PH_TRIG;
                            ch_pcnt[c]  = '0;
                        end else begin
                            ch_pcnt[c] = bump20(ch_pcnt[c]);
                        end
                    end
                    upr_pkg::PH_TRIG: begin
                        ch_pcnt[c] = bump20(ch_pcnt[c]);
                        if (ch_pcnt[c] >= trig_len) begin
                            ch_phase[c] = upr_pkg::PH_ARMED;
                            ch_pcnt[c]  = '0;
                        end
                    end
                    default: begin
                        finished = 1'b0;
                        if (ch_phase[c] == upr_pkg::PH_ARMED) begin
                            if (lvl_change) begin
                                ch_phase[c] = upr_pkg::PH_CAPT;
                                ch_ecnt[c]  = '0;
                            end
                        end else begin
                            if (ch_ecnt[c] != 16'hFFFF) ch_ecnt[c] = ch_ecnt[c] + 16'd1;
                            if (lvl_change) begin
                                ch_dist[c] = echo_to_cm(ch_ecnt[c]);
                                finished = 1'b1;
                            end
                        end
                        if (finished) begin
                            ch_phase[c] = upr_pkg::PH_REST;
                            ch_pcnt[c]  = '0;
                        end else begin
                            ch_pcnt[c] = bump20(ch_pcnt[c]);
                            if (ch_pcnt[c] >= timeout_len) begin
                                ch_dist[c]  = no_echo;
                                ch_phase[c] = upr_pkg::PH_REST;
                                ch_pcnt[c]  = '0;
                            end
                        end
                    end
                endcase
                if (ch_phase[c] == upr_pkg::PH_TRIG) o.trig_lines[c] = 1'b1;
                if (ch_dist[c] != old_d) o.upd_mask[c] = 1'b1;
            end
        end
        o.dist_front = ch_dist[0];
        o.dist_back  = ch_dist[1];
        o.dist_left  = ch_dist[2];
        o.dist_right = ch_dist[3];
        return o;
    endfunction

    function automatic tick_out_t mk_out(logic [3:0] trig, logic [9:0] d0, logic [9:0] d1,
                                         logic [9:0] d2, logic [9:0] d3, logic [3:0] upd);
        tick_out_t o;
        o.trig_lines = trig;
        o.dist_front = d0;
        o.dist_back  = d1;
        o.dist_left  = d2;
        o.dist_right = d3;
        o.upd_mask   = upd;
        return o;
    endfunction

    function automatic void push_write(upr_pkg::reg_idx_t idx, logic [19:0] v);
        dir_row_t r;
        r.kind = ROW_WRITE;
        r.idx  = idx;
        r.val  = v;
        r.lv   = '0;
        r.want = '0;
        dir_rows.push_back(r);
    endfunction

    function automatic void push_tick(logic [3:0] lv);
        dir_row_t r;
        r.kind = ROW_TICK;
        r.idx  = upr_pkg::REG_TRIGGER_TICKS;
        r.val  = '0;
        r.lv   = lv;
        r.want = '0;
        dir_rows.push_back(r);
    endfunction

    function automatic void push_known(logic [3:0] lv, tick_out_t want);
        dir_row_t r;
        r.kind = ROW_KNOWN;
        r.idx  = upr_pkg::REG_TRIGGER_TICKS;
        r.val  = '0;
        r.lv   = lv;
        r.want = want;
        dir_rows.push_back(r);
    endfunction

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 40) $display("mismatch @%0t: %s", $time, msg);
    endtask

    task automatic cmp_field(input string name, input logic [9:0] got, input logic [9:0] want);
        if (got !== want)
            report_mismatch($sformatf("beat %0d %s got %0d want %0d",
                                      results_seen, name, got, want));
    endtask

    task automatic check_result(input tick_out_t got);
        tick_out_t want;
        if (expected_q.size() == 0) begin
            report_mismatch($sformatf("unexpected beat %h", got));
            return;
        end
        want = expected_q.pop_front();
        cmp_field("trigger_lines",  10'(got.trig_lines), 10'(want.trig_lines));
        cmp_field("distance_front", got.dist_front, want.dist_front);
        cmp_field("distance_back",  got.dist_back,  want.dist_back);
        cmp_field("distance_left",  got.dist_left,  want.dist_left);
        cmp_field("distance_right", got.dist_right, want.dist_right);
        cmp_field("updated_mask",   10'(got.upd_mask), 10'(want.upd_mask));
        results_seen++;
        updates_seen += $countones(want.upd_mask);
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) check_result(m_tdata);
            m_tready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (expected_q.size() != 0) @(posedge aclk);
        repeat (2) @(posedge aclk);
    endtask

    task automatic cfg_write(input upr_pkg::reg_idx_t idx, input logic [19:0] v);
        if (!cfg_open) begin
            drain_results();
            cfg_open = 1'b1;
            cfg_settings++;
        end
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= v;
        @(posedge aclk);
        shadow_write(idx, v);
    endtask

    task automatic close_cfg();
        if (cfg_open) begin
            cfg_we  <= 1'b0;
            cfg_open = 1'b0;
        end
    endtask

    task automatic offer_tick(input logic [3:0] lv, input bit typed, input tick_out_t want);
        tick_out_t pred;
        close_cfg();
        if (ticks_sent < 190) begin
            send_idle_pct = 12;
            recv_idle_pct = 78;
        end else if (ticks_sent < 380) begin
            send_idle_pct = 78;
            recv_idle_pct = 12;
        end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end
        if ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0000, lv};
        do @(posedge aclk); while (!s_tready);
        pred = ranger_tick(lv);
        expected_q.push_back(typed ? want : pred);
        ticks_sent++;
    endtask

    // long output stall while beats keep coming
    initial begin
        wait (ticks_sent >= 250);
        @(posedge aclk);
        hold_off <= 1'b1;
        repeat (500) @(posedge aclk);
        hold_off <= 1'b0;
    end

    initial begin
        #1_500_000;
        $display("timeout, %0d beats still pending", expected_q.size());
        $display("[ultrasonic_ping_ranger] ERROR");
        $finish;
    end

    initial begin
        int          n;
        int          span;
        int          wait_cnt;
        int          gap_left [4];
        logic [3:0]  lvl_now;
        logic [3:0]  lv;

        ranger_reset();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset values: resting, edges ignored
        push_known(4'hF, mk_out(4'h0, 0, 0, 0, 0, 4'h0));
        push_known(4'hA, mk_out(4'h0, 0, 0, 0, 0, 4'h0));
        // zero rest, zero trigger length, zero timeout
        push_write(upr_pkg::REG_REST_TICKS, 20'd0);
        push_write(upr_pkg::REG_TRIGGER_TICKS, 20'd0);
        push_write(upr_pkg::REG_ECHO_TIMEOUT_TICKS, 20'd0);
        push_write(upr_pkg::REG_NO_ECHO_CODE, 20'd1023);
        push_known(4'h0, mk_out(4'hF, 0, 0, 0, 0, 4'h0));
        push_known(4'h0, mk_out(4'h0, 0, 0, 0, 0, 4'h0));
        push_known(4'h0, mk_out(4'h0, 1023, 1023, 1023, 1023, 4'hF));
        push_known(4'h0, mk_out(4'hF, 1023, 1023, 1023, 1023, 4'h0));
        // completion on the timeout tick
        push_write(upr_pkg::REG_ECHO_TIMEOUT_TICKS, 20'd3);
        push_write(upr_pkg::REG_TICKS_PER_CM, 20'd1);
        push_write(upr_pkg::REG_MIN_ECHO_TICKS, 20'd0);
        push_write(upr_pkg::REG_MAX_DISTANCE_CM, 20'd1023);
        push_tick(4'h0);
        push_tick(4'h1);
        push_tick(4'h1);
        push_tick(4'h0);
        push_tick(4'h0);
        // zero divisor
        push_write(upr_pkg::REG_TICKS_PER_CM, 20'd0);
        push_write(upr_pkg::REG_NO_ECHO_CODE, 20'd0);
        push_tick(4'h0);
        push_tick(4'h2);
        push_tick(4'h0);
        push_tick(4'h0);
        // too short, too far
        push_write(upr_pkg::REG_TICKS_PER_CM, 20'd1);
        push_write(upr_pkg::REG_MAX_DISTANCE_CM, 20'd0);
        push_write(upr_pkg::REG_MIN_ECHO_TICKS, 20'd2);
        push_write(upr_pkg::REG_ECHO_TIMEOUT_TICKS, 20'd65535);
        push_write(upr_pkg::REG_NO_ECHO_CODE, 20'd5);
        push_tick(4'h0);
        push_tick(4'h0);
        push_tick(4'h4);
        push_tick(4'h0);
        push_tick(4'h8);
        push_tick(4'h8);
        push_tick(4'h0);
        // disable mid-measurement, then re-enable; upper write bits are dropped
        push_write(upr_pkg::REG_CHANNEL_ENABLE, 20'd0);
        push_tick(4'hF);
        push_write(upr_pkg::REG_CHANNEL_ENABLE, 20'hFFFFF);
        push_write(upr_pkg::REG_TRIGGER_TICKS, 20'hFFF03);
        push_write(upr_pkg::REG_REST_TICKS, 20'd1);
        push_tick(4'hF);
        push_tick(4'h0);

        foreach (dir_rows[i]) begin
            case (dir_rows[i].kind)
                ROW_WRITE: cfg_write(dir_rows[i].idx, dir_rows[i].val);
                ROW_TICK:  offer_tick(dir_rows[i].lv, 1'b0, '0);
                default:   offer_tick(dir_rows[i].lv, 1'b1, dir_rows[i].want);
            endcase
        end

        lvl_now = 4'h0;
        for (int c = 0; c < 4; c++) gap_left[c] = $urandom_range(0, 5);

        for (int p = 0; p < 10; p++) begin
            if (p == 4) begin
                cfg_write(upr_pkg::REG_TRIGGER_TICKS, 20'd255);
                cfg_write(upr_pkg::REG_ECHO_TIMEOUT_TICKS, 20'd65535);
                cfg_write(upr_pkg::REG_REST_TICKS, 20'd0);
                cfg_write(upr_pkg::REG_TICKS_PER_CM, 20'd255);
                cfg_write(upr_pkg::REG_MIN_ECHO_TICKS, 20'd65535);
                cfg_write(upr_pkg::REG_MAX_DISTANCE_CM, 20'd1023);
                cfg_write(upr_pkg::REG_NO_ECHO_CODE, 20'd1023);
                cfg_write(upr_pkg::REG_CHANNEL_ENABLE, 20'd15);
                n = 30;
                span = 12;
            end else if (p == 7) begin
                cfg_write(upr_pkg::REG_TRIGGER_TICKS, 20'd1);
                cfg_write(upr_pkg::REG_ECHO_TIMEOUT_TICKS, 20'd1);
                cfg_write(upr_pkg::REG_REST_TICKS, 20'hFFFFF);
                cfg_write(upr_pkg::REG_TICKS_PER_CM, 20'd1);
                cfg_write(upr_pkg::REG_MIN_ECHO_TICKS, 20'd0);
                cfg_write(upr_pkg::REG_MAX_DISTANCE_CM, 20'd0);
                cfg_write(upr_pkg::REG_NO_ECHO_CODE, 20'd0);
                cfg_write(upr_pkg::REG_CHANNEL_ENABLE,
                          ($urandom_range(1) != 0) ? 20'd0 : 20'd15);
                n = 30;
                span = 3;
            end else begin
                cfg_write(upr_pkg::REG_TRIGGER_TICKS, 20'($urandom_range(1, 6)));
                cfg_write(upr_pkg::REG_ECHO_TIMEOUT_TICKS, 20'($urandom_range(6, 60)));
                cfg_write(upr_pkg::REG_REST_TICKS, 20'($urandom_range(0, 8)));
                case ($urandom_range(9))
                    0:       cfg_write(upr_pkg::REG_TICKS_PER_CM, 20'd0);
                    1:       cfg_write(upr_pkg::REG_TICKS_PER_CM, 20'd255);
                    default: cfg_write(upr_pkg::REG_TICKS_PER_CM, 20'($urandom_range(1, 6)));
                endcase
                cfg_write(upr_pkg::REG_MIN_ECHO_TICKS, 20'($urandom_range(0, 8)));
                cfg_write(upr_pkg::REG_MAX_DISTANCE_CM,
                          ($urandom_range(1) != 0) ? 20'd1023 : 20'($urandom_range(0, 40)));
                cfg_write(upr_pkg::REG_NO_ECHO_CODE, 20'($urandom_range(0, 1023)));
                cfg_write(upr_pkg::REG_CHANNEL_ENABLE,
                          ($urandom_range(3) == 0) ? 20'($urandom_range(0, 15)) : 20'd15);
                n = 60;
                span = $urandom_range(2, 30);
            end
            for (int k = 0; k < n; k++) begin
                for (int c = 0; c < 4; c++) begin
                    if (gap_left[c] == 0) begin
                        lvl_now[c] = ~lvl_now[c];
                        gap_left[c] = $urandom_range(1, span);
                    end else begin
                        gap_left[c]--;
                    end
                end
                lv = lvl_now;
                // glitch noise on top of the echo pulses
                if ($urandom_range(99) < 8) lv = lv ^ 4'($urandom_range(1, 15));
                offer_tick(lv, 1'b0, '0);
            end
        end

        close_cfg();
        s_tvalid <= 1'b0;
        wait_cnt = 0;
        while (expected_q.size() != 0 && wait_cnt < 20000) begin
            @(posedge aclk);
            wait_cnt++;
        end
        repeat (100) @(posedge aclk);
        if (expected_q.size() != 0)
            report_mismatch($sformatf("%0d beats never arrived", expected_q.size()));

        $display("%0d ticks over %0d register settings, %0d beats checked, %0d distance updates",
                 ticks_sent, cfg_settings, results_seen, updates_seen);
        $display("idle mixes: sender-light, receiver-light, none; one 500-cycle output stall");
        if (mismatches == 0) begin
            $display("[ultrasonic_ping_ranger] OK");
        end else begin
            $display("[ultrasonic_ping_ranger] ERROR");
        end
        $finish;
    end

endmodule
